// ----- src/rmm_pkg.sv -----
`default_nettype none
package rmm_pkg;
	localparam int Capacity = 64;
	localparam int ValueWidth = 32;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_MEDIAN = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef logic signed [ValueWidth-1:0] value_t;
endpackage
`default_nettype wire

// ----- src/running_median_multiset_unit.sv -----
`default_nettype none
// Channel   | Direction | Handshake              | Fields
// command   | in        | start high, busy low   | kind, value
// result    | out       | done strobe, one cycle | status, median_value, element_count
//
// An add or remove walks the sorted store one entry a cycle through a single
// RAM read port; a median query sets the read address, waits out the
// registered read and then reports the result.
// Reset clears the count, done, the sequencer and its scan flags; the store is
// never cleared, because no entry at or above the count is ever used.
// The receiver cannot stall: the result word is shown for one cycle with done.
module running_median_multiset_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              kind,
	input  wire logic signed [31:0]      value,
	output logic                         done,
	output logic [1:0]                   status,
	output logic signed [31:0]           median_value,
	output logic [6:0]                   element_count
);
	localparam int AW = rmm_pkg::AddrW;
	localparam int CW = rmm_pkg::CountW;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MED  = 3'd1; // median read in flight
	localparam logic [2:0] S_SCAN = 3'd2; // walking the store
	localparam logic [2:0] S_FIN  = 3'd3; // final write and report

	logic [2:0]          state_q;
	logic [1:0]          kind_q;
	rmm_pkg::value_t     val_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;    // index of the entry whose data arrives next cycle
	logic                rvalid_q; // read data corresponds to idx_q - 1
	logic                found_q;  // add: insertion point passed; remove: match found
	rmm_pkg::value_t     carry_q;  // add: value being shifted upward

	logic                we;
	logic [AW-1:0]       waddr;
	rmm_pkg::value_t     wdata;
	logic [AW-1:0]       raddr;
	rmm_pkg::value_t     rdata;

	rmm_ram #(.Width(rmm_pkg::ValueWidth), .Depth(rmm_pkg::Capacity)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign busy = (state_q != S_IDLE);

	// Index of the entry whose data is in rdata this cycle.
	logic [CW-1:0] cur_idx;
	assign cur_idx = idx_q - CW'(1);

	always_comb begin
		raddr = idx_q[AW-1:0];
		if (state_q == S_IDLE) begin
			raddr = (kind == rmm_pkg::KIND_MEDIAN) ? AW'((count_q - CW'(1)) >> 1) : '0;
		end
		if (state_q == S_MED) begin
			raddr = AW'((count_q - CW'(1)) >> 1);
		end
		we = 1'b0;
		waddr = cur_idx[AW-1:0];
		wdata = rdata;
		if (state_q == S_SCAN && rvalid_q) begin
			if (kind_q == rmm_pkg::KIND_ADD) begin
				// Entries above the new value move up by one; the write
				// trails the read so it never clobbers unread data.
				if (found_q) begin
					we = 1'b1;
					wdata = carry_q;
				end else if (rdata > val_q) begin
					we = 1'b1;
					wdata = val_q;
				end
			end else if (found_q) begin
				// Remove: each later entry moves down one place.
				we = 1'b1;
				waddr = AW'(cur_idx - CW'(1));
			end
		end
		if (state_q == S_FIN && kind_q == rmm_pkg::KIND_ADD) begin
			we = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = found_q ? carry_q : val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done <= 1'b0;
			idx_q <= '0;
			rvalid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						val_q <= value;
						found_q <= 1'b0;
						rvalid_q <= 1'b0;
						idx_q <= '0;
						case (kind)
							rmm_pkg::KIND_ADD: begin
								if (count_q >= CW'(rmm_pkg::Capacity)) begin
									done <= 1'b1;
									status <= rmm_pkg::ST_FULL;
									median_value <= '0;
									element_count <= 7'(count_q);
								end else begin
									state_q <= S_SCAN;
								end
							end
							rmm_pkg::KIND_REMOVE: begin
								state_q <= S_SCAN;
							end
							rmm_pkg::KIND_MEDIAN: begin
								if (count_q == '0) begin
									done <= 1'b1;
									status <= rmm_pkg::ST_EMPTY;
									median_value <= '0;
									element_count <= 7'(count_q);
								end else begin
									state_q <= S_MED;
								end
							end
							default: begin
								done <= 1'b1;
								status <= rmm_pkg::ST_OK;
								median_value <= '0;
								element_count <= 7'(count_q);
							end
						endcase
					end
				end
				S_MED: begin
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (rvalid_q && kind_q == rmm_pkg::KIND_ADD) begin
						if (found_q || rdata > val_q) begin
							found_q <= 1'b1;
							carry_q <= rdata;
						end
					end else if (rvalid_q && !found_q && rdata == val_q) begin
						found_q <= 1'b1;
					end
					if (idx_q >= count_q) begin
						state_q <= S_FIN;
						rvalid_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						rvalid_q <= 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					median_value <= '0;
					status <= rmm_pkg::ST_OK;
					element_count <= 7'(count_q);
					case (kind_q)
						rmm_pkg::KIND_ADD: begin
							count_q <= count_q + CW'(1);
							element_count <= 7'(count_q + CW'(1));
						end
						rmm_pkg::KIND_REMOVE: begin
							if (found_q) begin
								count_q <= count_q - CW'(1);
								element_count <= 7'(count_q - CW'(1));
							end else begin
								status <= rmm_pkg::ST_MISSING;
							end
						end
						default: begin
							median_value <= rdata;
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// S_FIN for a median takes the rdata of the read made during S_MED, not of
	// the one set up in S_IDLE, so S_MED keeps the median address on the port.

	chk_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(rmm_pkg::Capacity))
		else $error("count above capacity");
	chk_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(state_q) == S_IDLE)
		else $error("done while still busy");
	chk_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (count_q == $past(count_q)))
		else $error("count changed outside a command");
	chk_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(waddr) <= count_q))
		else $error("write beyond stored values");
endmodule
`default_nettype wire

// ----- src/rmm_ram.sv -----
`default_nettype none
// Single-port-write, single-port-read RAM with registered read data.
module rmm_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
